### rtl/agpc_pkg.sv
// ----------------------------------------------------------------------------
// agpc_pkg: shared definitions for the arc gauge pixel classifier
// Register indexes, field widths, ring offsets and the pipeline advance type.
// ----------------------------------------------------------------------------
`default_nettype none

package agpc_pkg;

  // Default parameter values.
  localparam int unsigned MaxDimDefault     = 1024;
  localparam int unsigned DirFracBitsDefault = 15;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW  = 10;
  localparam int unsigned DimW    = 11;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned DirW    = 32;
  localparam int unsigned CompW   = 16;
  localparam int unsigned PalW    = 48;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 3;

  // Doubled coordinate and squared distance widths.
  localparam int unsigned DxW = DimW + 2;
  localparam int unsigned D2W = 2 * DimW + 2;

  // Largest screen size the 11-bit registers can hold.
  localparam int unsigned DimRegMax = (1 << DimW) - 1;

  // sin(80) and cos(80) in Q2.30.
  localparam longint Sin80Q30 = 64'sd1057429273;
  localparam longint Cos80Q30 = 64'sd186453311;

  // Ring bounds relative to m = min(width, height), doubled units.
  localparam int OutBandLo = 14;
  localparam int OutBandHi = 4;
  localparam int OutFillLo = 10;
  localparam int OutFillHi = 0;
  localparam int InRingLo  = 32;
  localparam int InRingHi  = 20;

  // Reset values of the configuration registers.
  localparam logic [DimW-1:0]  ScreenWidthRst  = DimW'(240);
  localparam logic [DimW-1:0]  ScreenHeightRst = DimW'(240);
  localparam logic [ModeW-1:0] LayerModeRst    = ModeW'(1);

  // Layer mode bits.
  localparam int unsigned ModeOuterOn   = 0;
  localparam int unsigned ModeInnerOn   = 1;
  localparam int unsigned ModeOuterFill = 2;
  localparam int unsigned ModeInnerFill = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH   = 3'd0,
    CFG_SCREEN_HEIGHT  = 3'd1,
    CFG_LAYER_MODE     = 3'd2,
    CFG_OUTER_START    = 3'd3,
    CFG_OUTER_END      = 3'd4,
    CFG_INNER_START    = 3'd5,
    CFG_INNER_END      = 3'd6,
    CFG_PALETTE        = 3'd7
  } cfg_idx_e;

  // Load strobes for the two stages inside the sector test.
  typedef struct packed {
    logic prod;
    logic cmp;
  } adv_t;

endpackage : agpc_pkg

`default_nettype wire

### rtl/agpc_sector.sv
// ----------------------------------------------------------------------------
// agpc_sector: two-stage sector membership test
// Registers the four cross products, then the result of both edge tests.
// ----------------------------------------------------------------------------
`default_nettype none

module agpc_sector #(
  parameter int unsigned VW = agpc_pkg::CompW
) (
  input  wire                                 clk_i,
  input  agpc_pkg::adv_t                      adv_i,
  input  wire logic signed [agpc_pkg::DxW-1:0] dx_i,
  input  wire logic signed [agpc_pkg::DxW-1:0] dy_i,
  input  wire logic signed [VW-1:0]           start_x_i,
  input  wire logic signed [VW-1:0]           start_y_i,
  input  wire logic signed [VW-1:0]           end_x_i,
  input  wire logic signed [VW-1:0]           end_y_i,
  output logic                                inside_o
);

  localparam int unsigned PW = VW + agpc_pkg::DxW;

  logic signed [PW-1:0] sx_dy_q, sy_dx_q, ey_dx_q, ex_dy_q;
  logic                 inside_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      sx_dy_q <= start_x_i * dy_i;
      sy_dx_q <= start_y_i * dx_i;
      ey_dx_q <= end_y_i * dx_i;
      ex_dy_q <= end_x_i * dy_i;
    end
  end

  // Inside when Sx*dy - Sy*dx >= 0 and dx*Ey - dy*Ex >= 0.
  always_ff @(posedge clk_i) begin
    if (adv_i.cmp) begin
      inside_q <= (sx_dy_q >= sy_dx_q) && (ey_dx_q >= ex_dy_q);
    end
  end

  assign inside_o = inside_q;

endmodule : agpc_sector

`default_nettype wire

### rtl/arc_gauge_pixel_classifier.sv
// ----------------------------------------------------------------------------
// arc_gauge_pixel_classifier: gauge band classifier for a round display
// Decides per pixel whether it falls in the outer or inner gauge band inside
// the 160 degree sweep, and picks the fill or background colour.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   pixel in | in_valid_i, in_stall_o, pixel_x/y_i       | in
//   class out| out_valid_o, out_stall_i, write_enable_o,  | out
//            | pixel_color_o                             |
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// One beat per pixel is taken in every cycle while in_stall_o is low; the four
// register stages are offsets, products, sums and edge tests, and result.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and a stall holds every beat in place. Reset clears only the valid
// bits and the configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_gauge_pixel_classifier #(
  parameter int unsigned MAX_DIM       = agpc_pkg::MaxDimDefault,
  parameter int unsigned DIR_FRAC_BITS = agpc_pkg::DirFracBitsDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration write port.
  input  wire                                  cfg_we_i,
  input  wire logic [agpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [agpc_pkg::CfgW-1:0]       cfg_data_i,
  // Pixel input.
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [agpc_pkg::CoordW-1:0]     pixel_x_i,
  input  wire logic [agpc_pkg::CoordW-1:0]     pixel_y_i,
  // Classification output.
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 write_enable_o,
  output logic [agpc_pkg::ColorW-1:0]          pixel_color_o
);

  localparam int unsigned DimW   = agpc_pkg::DimW;
  localparam int unsigned DxW    = agpc_pkg::DxW;
  localparam int unsigned D2W    = agpc_pkg::D2W;
  localparam int unsigned CompW  = agpc_pkg::CompW;
  localparam int unsigned ColorW = agpc_pkg::ColorW;
  localparam int unsigned ModeW  = agpc_pkg::ModeW;
  localparam int unsigned DirW   = agpc_pkg::DirW;
  localparam int unsigned PalW   = agpc_pkg::PalW;
  localparam int unsigned SqW    = 2 * DxW;

  // A cap above what the register can hold never takes effect.
  localparam int unsigned DimCap = (MAX_DIM < agpc_pkg::DimRegMax) ?
                                   MAX_DIM : agpc_pkg::DimRegMax;

  // Sweep edge constants, Q2.30 rounded to DIR_FRAC_BITS fraction bits.
  localparam int unsigned FracShift = 30 - DIR_FRAC_BITS;
  localparam longint SinQ = (((agpc_pkg::Sin80Q30 * 2) >>> FracShift) + 1) >>> 1;
  localparam longint CosQ = (((agpc_pkg::Cos80Q30 * 2) >>> FracShift) + 1) >>> 1;
  localparam int unsigned CW = DIR_FRAC_BITS + 2;
  localparam logic signed [CW-1:0] SweepS    = CW'(SinQ);
  localparam logic signed [CW-1:0] SweepC    = CW'(CosQ);
  localparam logic signed [CW-1:0] SweepNegS = CW'(-SinQ);
  localparam logic signed [CW-1:0] SweepNegC = CW'(-CosQ);

  // ------------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------------
  logic [DimW-1:0]  screen_width_q, screen_height_q;
  logic [ModeW-1:0] layer_mode_q;
  logic [DirW-1:0]  outer_start_q, outer_end_q, inner_start_q, inner_end_q;
  logic [PalW-1:0]  palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= agpc_pkg::ScreenWidthRst;
      screen_height_q <= agpc_pkg::ScreenHeightRst;
      layer_mode_q    <= agpc_pkg::LayerModeRst;
      outer_start_q   <= '0;
      outer_end_q     <= '0;
      inner_start_q   <= '0;
      inner_end_q     <= '0;
      palette_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (agpc_pkg::cfg_idx_e'(cfg_idx_i))
        agpc_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[DimW-1:0];
        agpc_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[DimW-1:0];
        agpc_pkg::CFG_LAYER_MODE:    layer_mode_q    <= cfg_data_i[ModeW-1:0];
        agpc_pkg::CFG_OUTER_START:   outer_start_q   <= cfg_data_i[DirW-1:0];
        agpc_pkg::CFG_OUTER_END:     outer_end_q     <= cfg_data_i[DirW-1:0];
        agpc_pkg::CFG_INNER_START:   inner_start_q   <= cfg_data_i[DirW-1:0];
        agpc_pkg::CFG_INNER_END:     inner_end_q     <= cfg_data_i[DirW-1:0];
        agpc_pkg::CFG_PALETTE:       palette_q       <= cfg_data_i[PalW-1:0];
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Stage valid bits and the load chain. A stage loads when it is empty or
  // when the stage after it in the flow moves on.
  // ------------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic ld_a, ld_b, ld_c, ld_d;

  assign ld_d = !d_valid_q || !out_stall_i;
  assign ld_c = !c_valid_q || ld_d;
  assign ld_b = !b_valid_q || ld_c;
  assign ld_a = !a_valid_q || ld_b;

  assign in_stall_o = !ld_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (ld_a) a_valid_q <= in_valid_i;
      if (ld_b) b_valid_q <= a_valid_q;
      if (ld_c) c_valid_q <= b_valid_q;
      if (ld_d) d_valid_q <= c_valid_q;
    end
  end

  // ------------------------------------------------------------------------
  // Stage A: clamp the screen size, center the pixel in doubled units, and
  // flag pixels that fall off the screen.
  // ------------------------------------------------------------------------
  logic [DimW-1:0]       w_sat, h_sat, m_d;
  logic signed [DxW-1:0] dx_d, dy_d;
  logic                  onscreen_d;

  always_comb begin
    w_sat = (32'(screen_width_q) > DimCap) ? DimW'(DimCap) : screen_width_q;
    h_sat = (32'(screen_height_q) > DimCap) ? DimW'(DimCap) : screen_height_q;
    m_d   = (w_sat < h_sat) ? w_sat : h_sat;
    dx_d  = $signed({2'b00, pixel_x_i, 1'b1}) - $signed({2'b00, w_sat});
    dy_d  = $signed({2'b00, pixel_y_i, 1'b1}) - $signed({2'b00, h_sat});
    onscreen_d = ({1'b0, pixel_x_i} < w_sat) && ({1'b0, pixel_y_i} < h_sat);
  end

  logic signed [DxW-1:0] a_dx_q, a_dy_q;
  logic [DimW-1:0]       a_m_q;
  logic                  a_on_q;

  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_dx_q <= dx_d;
      a_dy_q <= dy_d;
      a_m_q  <= m_d;
      a_on_q <= onscreen_d;
    end
  end

  // ------------------------------------------------------------------------
  // Stage B: squares of the offsets and of every ring bound.
  // ------------------------------------------------------------------------
  logic signed [DxW-1:0] m_s;
  logic signed [DxW-1:0] ob_lo, ob_hi, of_lo, of_hi, ir_lo, ir_hi;
  logic signed [SqW-1:0] dx_sq, dy_sq;
  logic signed [SqW-1:0] ob_lo_sq, ob_hi_sq, of_lo_sq, of_hi_sq, ir_lo_sq, ir_hi_sq;

  always_comb begin
    m_s   = $signed({2'b00, a_m_q});
    ob_lo = m_s - DxW'(agpc_pkg::OutBandLo);
    ob_hi = m_s + DxW'(agpc_pkg::OutBandHi);
    of_lo = m_s - DxW'(agpc_pkg::OutFillLo);
    of_hi = m_s - DxW'(agpc_pkg::OutFillHi);
    ir_lo = m_s - DxW'(agpc_pkg::InRingLo);
    ir_hi = m_s - DxW'(agpc_pkg::InRingHi);
    dx_sq    = a_dx_q * a_dx_q;
    dy_sq    = a_dy_q * a_dy_q;
    ob_lo_sq = ob_lo * ob_lo;
    ob_hi_sq = ob_hi * ob_hi;
    of_lo_sq = of_lo * of_lo;
    of_hi_sq = of_hi * of_hi;
    ir_lo_sq = ir_lo * ir_lo;
    ir_hi_sq = ir_hi * ir_hi;
  end

  logic [D2W-1:0] b_dx_sq_q, b_dy_sq_q;
  logic [D2W-1:0] b_ob_lo_q, b_ob_hi_q, b_of_lo_q, b_of_hi_q, b_ir_lo_q, b_ir_hi_q;
  logic           b_on_q;

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      b_dx_sq_q <= dx_sq[D2W-1:0];
      b_dy_sq_q <= dy_sq[D2W-1:0];
      b_ob_lo_q <= ob_lo_sq[D2W-1:0];
      b_ob_hi_q <= ob_hi_sq[D2W-1:0];
      b_of_lo_q <= of_lo_sq[D2W-1:0];
      b_of_hi_q <= of_hi_sq[D2W-1:0];
      b_ir_lo_q <= ir_lo_sq[D2W-1:0];
      b_ir_hi_q <= ir_hi_sq[D2W-1:0];
      b_on_q    <= a_on_q;
    end
  end

  // The three sector tests run their products in stage B and their edge
  // compares in stage C, in step with the ring path.
  agpc_pkg::adv_t sec_adv;
  logic           full_in, ofill_in, ifill_in;

  assign sec_adv.prod = ld_b;
  assign sec_adv.cmp  = ld_c;

  agpc_sector #(.VW(CW)) u_full_sector (
    .clk_i     (clk_i),
    .adv_i     (sec_adv),
    .dx_i      (a_dx_q),
    .dy_i      (a_dy_q),
    .start_x_i (SweepNegS),
    .start_y_i (SweepNegC),
    .end_x_i   (SweepS),
    .end_y_i   (SweepNegC),
    .inside_o  (full_in)
  );

  agpc_sector #(.VW(CompW)) u_outer_sector (
    .clk_i     (clk_i),
    .adv_i     (sec_adv),
    .dx_i      (a_dx_q),
    .dy_i      (a_dy_q),
    .start_x_i ($signed(outer_start_q[DirW-1:CompW])),
    .start_y_i ($signed(outer_start_q[CompW-1:0])),
    .end_x_i   ($signed(outer_end_q[DirW-1:CompW])),
    .end_y_i   ($signed(outer_end_q[CompW-1:0])),
    .inside_o  (ofill_in)
  );

  agpc_sector #(.VW(CompW)) u_inner_sector (
    .clk_i     (clk_i),
    .adv_i     (sec_adv),
    .dx_i      (a_dx_q),
    .dy_i      (a_dy_q),
    .start_x_i ($signed(inner_start_q[DirW-1:CompW])),
    .start_y_i ($signed(inner_start_q[CompW-1:0])),
    .end_x_i   ($signed(inner_end_q[DirW-1:CompW])),
    .end_y_i   ($signed(inner_end_q[CompW-1:0])),
    .inside_o  (ifill_in)
  );

  // ------------------------------------------------------------------------
  // Stage C: squared distance from the center.
  // ------------------------------------------------------------------------
  logic [D2W-1:0] c_d2_q;
  logic [D2W-1:0] c_ob_lo_q, c_ob_hi_q, c_of_lo_q, c_of_hi_q, c_ir_lo_q, c_ir_hi_q;
  logic           c_on_q;

  always_ff @(posedge clk_i) begin
    if (ld_c) begin
      c_d2_q    <= b_dx_sq_q + b_dy_sq_q;
      c_ob_lo_q <= b_ob_lo_q;
      c_ob_hi_q <= b_ob_hi_q;
      c_of_lo_q <= b_of_lo_q;
      c_of_hi_q <= b_of_hi_q;
      c_ir_lo_q <= b_ir_lo_q;
      c_ir_hi_q <= b_ir_hi_q;
      c_on_q    <= b_on_q;
    end
  end

  // ------------------------------------------------------------------------
  // Stage D: ring tests, band priority and colour choice. A ring whose lower
  // bound squared exceeds its upper bound squared matches nothing.
  // ------------------------------------------------------------------------
  logic              in_outer, in_inner, in_ofill_ring, fill_outer, fill_inner;
  logic              we_d;
  logic [ColorW-1:0] color_d;

  always_comb begin
    in_outer = layer_mode_q[agpc_pkg::ModeOuterOn]
               && (c_d2_q >= c_ob_lo_q) && (c_d2_q <= c_ob_hi_q);
    in_inner = layer_mode_q[agpc_pkg::ModeInnerOn]
               && (c_d2_q >= c_ir_lo_q) && (c_d2_q <= c_ir_hi_q);
    in_ofill_ring = (c_d2_q >= c_of_lo_q) && (c_d2_q <= c_of_hi_q);
    fill_outer = layer_mode_q[agpc_pkg::ModeOuterFill] && in_ofill_ring && ofill_in;
    fill_inner = layer_mode_q[agpc_pkg::ModeInnerFill] && ifill_in;
    we_d = c_on_q && (in_outer || in_inner) && full_in;
    if (!we_d) begin
      color_d = '0;
    end else if (in_outer) begin
      color_d = fill_outer ? palette_q[47:32] : palette_q[15:0];
    end else begin
      color_d = fill_inner ? palette_q[31:16] : palette_q[15:0];
    end
  end

  logic              d_we_q;
  logic [ColorW-1:0] d_color_q;

  always_ff @(posedge clk_i) begin
    if (ld_d) begin
      d_we_q    <= we_d;
      d_color_q <= color_d;
    end
  end

  assign out_valid_o    = d_valid_q;
  assign write_enable_o = d_we_q;
  assign pixel_color_o  = d_color_q;

endmodule : arc_gauge_pixel_classifier

`default_nettype wire

### tb/tb_arc_gauge_pixel_classifier.sv
// ----------------------------------------------------------------------------
// tb_arc_gauge_pixel_classifier: self-checking bench for the gauge classifier
// Drives pixel beats through the valid/stall input channel, predicts the band
// decision and colour of every accepted pixel, and compares each output beat
// against the oldest prediction, field by field, under random idling.
// ----------------------------------------------------------------------------

module tb_arc_gauge_pixel_classifier;

  localparam int unsigned CoordW        = agpc_pkg::CoordW;
  localparam int unsigned DimW          = agpc_pkg::DimW;
  localparam int unsigned ModeW         = agpc_pkg::ModeW;
  localparam int unsigned DirW          = agpc_pkg::DirW;
  localparam int unsigned CompW         = agpc_pkg::CompW;
  localparam int unsigned PalW          = agpc_pkg::PalW;
  localparam int unsigned ColorW        = agpc_pkg::ColorW;
  localparam int unsigned CfgW          = agpc_pkg::CfgW;
  localparam int unsigned CfgIdxW       = agpc_pkg::CfgIdxW;
  localparam int unsigned ModeOuterOn   = agpc_pkg::ModeOuterOn;
  localparam int unsigned ModeInnerOn   = agpc_pkg::ModeInnerOn;
  localparam int unsigned ModeOuterFill = agpc_pkg::ModeOuterFill;
  localparam int unsigned ModeInnerFill = agpc_pkg::ModeInnerFill;

  // Screen sizes above this saturate inside the block.
  localparam int unsigned MaxDim = 1024;

  // The fixed 160 degree sweep is bounded by (-sin80, -cos80) and
  // (sin80, -cos80), both held with 15 fraction bits, rounded to nearest.
  localparam longint SweepSin = 32270;
  localparam longint SweepCos = 5690;

  // Ring bounds as offsets from m = min(width, height), in doubled units.
  localparam int OuterBandIn  = 14;
  localparam int OuterBandOut = 4;
  localparam int OuterFillIn  = 10;
  localparam int OuterFillOut = 0;
  localparam int InnerRingIn  = 32;
  localparam int InnerRingOut = 20;

  localparam logic [ModeW-1:0] AllLayers =
    ModeW'((1 << ModeOuterOn) | (1 << ModeInnerOn) |
           (1 << ModeOuterFill) | (1 << ModeInnerFill));

  // Watchdog limit in cycles without any accepted beat. The longest correct
  // quiet stretch is the receiver hold-off plus a stall burst, or the eight
  // register writes of a phase change, both far below this.
  localparam int StallLimit  = 1000;
  localparam int HoldCycles  = 40;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic              write_en;
    logic [ColorW-1:0] color;
  } pixel_class_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgW-1:0]     cfg_data  = '0;
  logic                pix_valid = 1'b0;
  logic                pix_stall;
  logic [CoordW-1:0]   pix_x     = '0;
  logic [CoordW-1:0]   pix_y     = '0;
  logic                cls_valid;
  logic                cls_stall = 1'b0;
  logic                cls_we;
  logic [ColorW-1:0]   cls_color;

  // Bench copy of the configuration registers, starting at their reset values.
  logic [DimW-1:0]     gauge_width       = DimW'(240);
  logic [DimW-1:0]     gauge_height      = DimW'(240);
  logic [ModeW-1:0]    gauge_mode        = ModeW'(1);
  logic [DirW-1:0]     gauge_outer_start = '0;
  logic [DirW-1:0]     gauge_outer_end   = '0;
  logic [DirW-1:0]     gauge_inner_start = '0;
  logic [DirW-1:0]     gauge_inner_end   = '0;
  logic [PalW-1:0]     gauge_palette     = '0;

  // Predicted classifications in acceptance order.
  pixel_class_t        class_q[$];
  int unsigned         mismatches    = 0;
  int                  hold_requests = 0;
  bit                  tx_gaps_on    = 1'b1;
  bit                  rx_stalls_on  = 1'b1;

  arc_gauge_pixel_classifier uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (pix_valid),
    .in_stall_o    (pix_stall),
    .pixel_x_i     (pix_x),
    .pixel_y_i     (pix_y),
    .out_valid_o   (cls_valid),
    .out_stall_i   (cls_stall),
    .write_enable_o(cls_we),
    .pixel_color_o (cls_color)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A ring whose inner bound squared exceeds its outer bound squared is empty.
  // Negative bounds on small screens are squared as they are.
  function automatic bit ring_hit(longint d2, longint lo, longint hi);
    return (d2 >= lo * lo) && (d2 <= hi * hi);
  endfunction

  // Inside the wedge that turns clockwise (y down) from edge s to edge e.
  // A zero edge vector makes its cross product zero, which counts as inside.
  function automatic bit sector_hit(longint dx, longint dy, longint sx, longint sy,
                                    longint ex, longint ey);
    return (sx * dy - sy * dx >= 0) && (dx * ey - dy * ex >= 0);
  endfunction

  function automatic bit dir_sector_hit(longint dx, longint dy, logic [DirW-1:0] s,
                                        logic [DirW-1:0] e);
    return sector_hit(dx, dy, longint'($signed(s[31:16])), longint'($signed(s[15:0])),
                      longint'($signed(e[31:16])), longint'($signed(e[15:0])));
  endfunction

  // Works in doubled units around the pixel middle so every test is exact.
  function automatic pixel_class_t classify_pixel(logic [CoordW-1:0] px,
                                                  logic [CoordW-1:0] py);
    longint       w, h, m, dx, dy, d2;
    bit           hit_outer, hit_inner, fill;
    pixel_class_t res;
    res = '0;
    w = (gauge_width > MaxDim) ? MaxDim : gauge_width;
    h = (gauge_height > MaxDim) ? MaxDim : gauge_height;
    // Off-screen pixels, which is every pixel on a zero-sized screen, are
    // never written.
    if (longint'(px) >= w || longint'(py) >= h) return res;
    m  = (w < h) ? w : h;
    dx = 2 * longint'(px) + 1 - w;
    dy = 2 * longint'(py) + 1 - h;
    d2 = dx * dx + dy * dy;
    hit_outer = gauge_mode[ModeOuterOn] &&
                ring_hit(d2, m - OuterBandIn, m + OuterBandOut);
    hit_inner = gauge_mode[ModeInnerOn] &&
                ring_hit(d2, m - InnerRingIn, m - InnerRingOut);
    if (!(hit_outer || hit_inner)) return res;
    if (!sector_hit(dx, dy, -SweepSin, -SweepCos, SweepSin, -SweepCos)) return res;
    res.write_en = 1'b1;
    // The outer band wins where the two bands overlap.
    if (hit_outer) begin
      fill = gauge_mode[ModeOuterFill] &&
             ring_hit(d2, m - OuterFillIn, m - OuterFillOut) &&
             dir_sector_hit(dx, dy, gauge_outer_start, gauge_outer_end);
      res.color = fill ? gauge_palette[47:32] : gauge_palette[15:0];
    end else begin
      fill = gauge_mode[ModeInnerFill] &&
             dir_sector_hit(dx, dy, gauge_inner_start, gauge_inner_end);
      res.color = fill ? gauge_palette[31:16] : gauge_palette[15:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: the receiver stalls in random bursts, or for one long
  // hold-off per request, counted here so that the sender keeps offering
  // beats meanwhile and the pipeline fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int hold_left;
    int burst_left;
    int holds_seen;
    hold_left  = 0;
    burst_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        cls_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        cls_stall <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 13) - 1;
        cls_stall <= 1'b1;
      end else begin
        cls_stall <= 1'b0;
      end
    end
  end

  // Every output beat must match the oldest prediction in both fields.
  always @(posedge clk) begin : class_checker
    pixel_class_t want;
    if (rst_n && cls_valid && !cls_stall) begin
      if (class_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual we=%0b color=%h",
                 $time, cls_we, cls_color);
        mismatches++;
      end else begin
        want = class_q.pop_front();
        if (cls_we !== want.write_en) begin
          $display("%0t: write_enable mismatch: expected %0b, actual %0b",
                   $time, want.write_en, cls_we);
          mismatches++;
        end
        if (cls_color !== want.color) begin
          $display("%0t: pixel_color mismatch: expected %h, actual %h",
                   $time, want.color, cls_color);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((pix_valid && !pix_stall) || (cls_valid && !cls_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_arc_gauge_pixel_classifier: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side and configuration
  // --------------------------------------------------------------------------

  // Offers one pixel and holds it until accepted. Valid stays high afterwards
  // so back-to-back beats need no re-assertion; a gap or a drain lowers it.
  task automatic send_pixel(int x, int y);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_x     <= CoordW'(x);
    pix_y     <= CoordW'(y);
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    class_q.push_back(classify_pixel(CoordW'(x), CoordW'(y)));
  endtask

  // Stops offering and waits until every predicted beat has come out.
  task automatic drain_results();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(agpc_pkg::cfg_idx_e idx, logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      agpc_pkg::CFG_SCREEN_WIDTH:  gauge_width       = data[DimW-1:0];
      agpc_pkg::CFG_SCREEN_HEIGHT: gauge_height      = data[DimW-1:0];
      agpc_pkg::CFG_LAYER_MODE:    gauge_mode        = data[ModeW-1:0];
      agpc_pkg::CFG_OUTER_START:   gauge_outer_start = data[DirW-1:0];
      agpc_pkg::CFG_OUTER_END:     gauge_outer_end   = data[DirW-1:0];
      agpc_pkg::CFG_INNER_START:   gauge_inner_start = data[DirW-1:0];
      agpc_pkg::CFG_INNER_END:     gauge_inner_end   = data[DirW-1:0];
      agpc_pkg::CFG_PALETTE:       gauge_palette     = data[PalW-1:0];
    endcase
  endtask

  // Empties the pipeline and lowers valid, then rewrites the whole register
  // set, so no beat is in flight while the registers change.
  task automatic set_gauge(int w, int h, logic [ModeW-1:0] mode,
                           logic [DirW-1:0] os_dir, logic [DirW-1:0] oe_dir,
                           logic [DirW-1:0] is_dir, logic [DirW-1:0] ie_dir,
                           logic [PalW-1:0] pal);
    drain_results();
    write_reg(agpc_pkg::CFG_SCREEN_WIDTH, CfgW'(w));
    write_reg(agpc_pkg::CFG_SCREEN_HEIGHT, CfgW'(h));
    write_reg(agpc_pkg::CFG_LAYER_MODE, CfgW'(mode));
    write_reg(agpc_pkg::CFG_OUTER_START, CfgW'(os_dir));
    write_reg(agpc_pkg::CFG_OUTER_END, CfgW'(oe_dir));
    write_reg(agpc_pkg::CFG_INNER_START, CfgW'(is_dir));
    write_reg(agpc_pkg::CFG_INNER_END, CfgW'(ie_dir));
    write_reg(agpc_pkg::CFG_PALETTE, CfgW'(pal));
  endtask

  // Mostly unit vectors within 110 degrees of straight up, some raw words so every bit
  // of the edge registers toggles, and some zero vectors.
  function automatic logic [DirW-1:0] random_dir();
    real                     a;
    logic signed [CompW-1:0] vx, vy;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return DirW'($urandom);
      default: begin
        a  = (real'($urandom_range(0, 220)) - 110.0) * 3.14159265358979 / 180.0;
        vx = CompW'($rtoi(32767.0 * $sin(a)));
        vy = CompW'($rtoi(-32767.0 * $cos(a)));
        return {vx, vy};
      end
    endcase
  endfunction

  // Mostly ordinary sizes, with small, oversized and zero screens mixed in.
  function automatic int random_dim();
    case ($urandom_range(0, 19))
      0: return 0;
      1, 2: return $urandom_range(1, 40);
      3: return $urandom_range(MaxDim + 1, (1 << DimW) - 1);
      default: return $urandom_range(16, MaxDim);
    endcase
  endfunction

  // Most pixels are aimed at a radius that straddles the bands, in the upper
  // part of the circle where the sweep lies; the rest are plain noise, on
  // screen or anywhere in the coordinate range.
  task automatic send_random_pixel();
    int w, h, m, r, dx, dy, x, y;
    w = (gauge_width > MaxDim) ? MaxDim : gauge_width;
    h = (gauge_height > MaxDim) ? MaxDim : gauge_height;
    if (w == 0 || h == 0 || $urandom_range(0, 9) < 3) begin
      if (w == 0 || h == 0 || $urandom_range(0, 1) == 0) begin
        x = $urandom_range(0, (1 << CoordW) - 1);
        y = $urandom_range(0, (1 << CoordW) - 1);
      end else begin
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
      end
    end else begin
      m = (w < h) ? w : h;
      r = m - InnerRingIn - 4 + $urandom_range(0, 44);
      y = (h - m) / 2 + $urandom_range(0, (m * 3) / 5);
      if (y > h - 1) y = h - 1;
      dy = 2 * y + 1 - h;
      dx = (r * r > dy * dy) ? $rtoi($sqrt(real'(r * r - dy * dy))) : 0;
      if ($urandom_range(0, 1) == 1) dx = -dx;
      x = (dx + w - 1) / 2;
      if (x < 0) x = 0;
      if (x > w - 1) x = w - 1;
    end
    send_pixel(x, y);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration: 240x240, outer band only, all colours zero.
  task automatic test_reset_defaults();
    send_pixel(120, 4);
    send_pixel(0, 0);
    send_pixel(235, 99);
    drain_results();
  endtask

  // Pixels either side of both 80 degree sweep edges, plus fill rings with
  // zero fill vectors, which cover the whole ring.
  task automatic test_sweep_edges();
    set_gauge(240, 240, AllLayers, '0, '0, '0, '0, 48'h1234_5678_9ABC);
    send_pixel(235, 99);
    send_pixel(235, 100);
    send_pixel(4, 99);
    send_pixel(4, 100);
    send_pixel(120, 4);
    send_pixel(120, 12);
    drain_results();
  endtask

  // Largest legal screen, extreme coordinates and full-scale edge vectors.
  task automatic test_extreme_fields();
    set_gauge(MaxDim, MaxDim, AllLayers, 32'h8000_8000, 32'h7FFF_7FFF,
              32'h7FFF_8000, 32'h8000_7FFF, 48'hFFFF_0000_FFFF);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 2);
    send_pixel(1023, 0);
    send_pixel(511, 511);
    drain_results();
  endtask

  // Width and height above the limit saturate to it.
  task automatic test_oversized_screen();
    set_gauge((1 << DimW) - 1, 1500, AllLayers, '0, 32'h7FFF_0000, '0, '0,
              48'hA5A5_5A5A_0F0F);
    send_pixel(1023, 1023);
    send_pixel(512, 2);
    drain_results();
  endtask

  // A zero width or height leaves no pixel on screen.
  task automatic test_zero_screen();
    set_gauge(0, 240, AllLayers, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_pixel(0, 0);
    send_pixel(120, 4);
    set_gauge(240, 0, AllLayers, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_pixel(120, 4);
    drain_results();
  endtask

  // Tiny screens give negative ring bounds; some rings become empty and the
  // inner ring of a 32 pixel screen reaches the centre.
  task automatic test_small_display();
    set_gauge(1, 1, AllLayers, '0, '0, '0, '0, 48'h0001_0002_0003);
    send_pixel(0, 0);
    set_gauge(32, 32, AllLayers, '0, '0, '0, '0, 48'h0001_0002_0003);
    send_pixel(15, 15);
    send_pixel(16, 0);
    send_pixel(31, 31);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    set_gauge(240, 240, AllLayers, random_dir(), random_dir(), random_dir(),
              random_dir(), PalW'({$urandom, $urandom}));
    hold_requests++;
    repeat (24) send_random_pixel();
    drain_results();
  endtask

  task automatic test_random_phase(bit gaps, bit stalls, int beats);
    int w, h;
    tx_gaps_on   = gaps;
    rx_stalls_on = stalls;
    w = random_dim();
    h = ($urandom_range(0, 1) == 1) ? w : random_dim();
    set_gauge(w, h, ModeW'($urandom_range(0, 15)), random_dir(), random_dir(),
              random_dir(), random_dir(), PalW'({$urandom, $urandom}));
    repeat (beats) send_random_pixel();
    drain_results();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_sweep_edges();
    test_extreme_fields();
    test_oversized_screen();
    test_zero_screen();
    test_small_display();
    test_backpressure();
    for (int i = 0; i < 9; i++) begin
      test_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 45);
    end
    // The closing phase runs at full rate on both sides.
    test_random_phase(1'b0, 1'b0, 45);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && class_q.size() == 0) begin
      $display("tb_arc_gauge_pixel_classifier: PASS");
    end else begin
      $display("tb_arc_gauge_pixel_classifier: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/agpc_pkg.sv
rtl/agpc_sector.sv
rtl/arc_gauge_pixel_classifier.sv
tb/tb_arc_gauge_pixel_classifier.sv
